// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the bounding box table RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define BBT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define BBT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/bbt_pkg.sv -----
// Package for the label bounding box table: field widths, codes, shared types.
// No dependencies; used by every other file of the block but assert_macros.svh.
`default_nettype none

package bbt_pkg;

	// Parameter defaults
	localparam int LABEL_ENTRIES_DEF = 256;
	localparam int COORD_BITS_DEF    = 12;

	// Fixed field widths
	localparam int LABEL_W    = 16;
	localparam int PIX_W      = 12;
	localparam int OFFS_W     = 12;
	localparam int REGION_W   = 13;
	localparam int AREA_W     = 2 * REGION_W;
	localparam int BOX_MIN_W  = 13;
	localparam int BOX_MAX_W  = 14;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	// Register reset values
	localparam logic [REGION_W-1:0] REGION_WIDTH_RST  = 13'd640;
	localparam logic [REGION_W-1:0] REGION_HEIGHT_RST = 13'd480;

	// Item function codes
	typedef enum logic {
		FUNC_PIXEL  = 1'b0,
		FUNC_REPORT = 1'b1
	} func_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X_OFFSET = 2'd0,
		REG_Y_OFFSET = 2'd1,
		REG_WIDTH    = 2'd2,
		REG_HEIGHT   = 2'd3
	} cfg_reg_t;

	// Settings seen by the datapath
	typedef struct packed {
		logic [OFFS_W-1:0] x_off;
		logic [OFFS_W-1:0] y_off;
		logic [AREA_W-1:0] area;
	} cfg_t;

	// Report fields handed from the table stage to the area stage
	typedef struct packed {
		logic [LABEL_W-1:0]   label;
		logic                 seen;
		logic                 out_of_range;
		logic [BOX_MIN_W-1:0] xmin;
		logic [BOX_MAX_W-1:0] xmax;
		logic [BOX_MIN_W-1:0] ymin;
		logic [BOX_MAX_W-1:0] ymax;
	} rpt_t;

endpackage

`default_nettype wire

// ----- rtl/core/bbt_intf.sv -----
// Channel interfaces of the bounding box table: items, results, configuration.
// Depends on bbt_pkg for field widths.
`default_nettype none

// Input items: pixels and report requests
interface bbt_item_if;
	logic                         valid;
	logic                         ready;
	logic                         func;
	logic [bbt_pkg::PIX_W-1:0]    pixel_x;
	logic [bbt_pkg::PIX_W-1:0]    pixel_y;
	logic [bbt_pkg::LABEL_W-1:0]  label_value;

	modport source (output valid, func, pixel_x, pixel_y, label_value, input ready);
	modport sink   (input valid, func, pixel_x, pixel_y, label_value, output ready);
endinterface

// Result items: one per report
interface bbt_result_if;
	logic                           valid;
	logic                           ready;
	logic [bbt_pkg::LABEL_W-1:0]    report_label;
	logic                           seen;
	logic                           kept;
	logic                           out_of_range;
	logic [bbt_pkg::BOX_MIN_W-1:0]  box_xmin;
	logic [bbt_pkg::BOX_MAX_W-1:0]  box_xmax;
	logic [bbt_pkg::BOX_MIN_W-1:0]  box_ymin;
	logic [bbt_pkg::BOX_MAX_W-1:0]  box_ymax;

	modport source (output valid, report_label, seen, kept, out_of_range,
		box_xmin, box_xmax, box_ymin, box_ymax, input ready);
	modport sink   (input valid, report_label, seen, kept, out_of_range,
		box_xmin, box_xmax, box_ymin, box_ymax, output ready);
endinterface

// Configuration register writes
interface bbt_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [bbt_pkg::CFG_IDX_W-1:0]    index;
	logic [bbt_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/label_bounding_box_table_top.sv -----
// Top level of the label bounding box table: box memory with its
// read-modify-write stage, clearing pass, and the two submodules.
// Depends on bbt_pkg, bbt_intf, bbt_cfg_regs, bbt_area_check, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// Keeps one bounding box per label in a LABEL_ENTRIES-deep memory with a
// registered read. A pixel item reads its label's entry, widens the box in the
// next cycle and writes it back; a report item reads the entry, writes it back
// cleared and sends one result through the area stage and the result register.
// Items are taken at one per cycle unless the input is held; an entry written
// by the item just ahead is forwarded, so repeated labels do not stall. Apart
// from clearing, only a report holds the input, and only while the area stage
// and result register are full and the result is not taken. After reset a
// clearing pass writes every entry, one per cycle; no item is taken during it,
// configuration writes are. Configuration must be written only while idle.
module label_bounding_box_table_top #(
	parameter int LABEL_ENTRIES = bbt_pkg::LABEL_ENTRIES_DEF,
	parameter int COORD_BITS    = bbt_pkg::COORD_BITS_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	bbt_item_if.sink      items,
	bbt_result_if.source  results,
	bbt_cfg_if.sink       cfg
);

	localparam int AW      = (LABEL_ENTRIES > 1) ? $clog2(LABEL_ENTRIES) : 1;
	localparam int CB      = COORD_BITS;
	localparam int ENTRY_W = 1 + 4 * CB;
	localparam int SUM_W   = ((CB > bbt_pkg::OFFS_W) ? CB : bbt_pkg::OFFS_W) + 2;
	localparam int DIM_W   = CB + 1;

	bbt_pkg::cfg_t          settings;

	// Box memory, entry = {present, xmin, xmax, ymin, ymax}
	logic [ENTRY_W-1:0]     box_mem [LABEL_ENTRIES];
	logic [ENTRY_W-1:0]     rdata_s1;
	logic                   mem_we;
	logic [AW-1:0]          mem_waddr;
	logic [ENTRY_W-1:0]     mem_wdata;

	// Clearing pass
	logic                   clr_busy_q;
	logic [AW-1:0]          clr_idx_q;

	// Input side
	logic                   in_xfer;
	logic [AW-1:0]          idx_in;
	logic                   in_range_in;

	// Table stage
	logic                   s1_valid_q;
	bbt_pkg::func_t         s1_func_q;
	logic [CB-1:0]          s1_x_q;
	logic [CB-1:0]          s1_y_q;
	logic [bbt_pkg::LABEL_W-1:0] s1_label_q;
	logic                   s1_inrange_q;
	logic [AW-1:0]          s1_idx_q;
	logic                   s1_fwd_q;
	logic [ENTRY_W-1:0]     s1_fwd_data_q;
	logic                   s1_adv;
	logic                   s2_ready;
	logic                   rpt_push;
	logic                   dropped_q;

	logic [ENTRY_W-1:0]     entry_s1;
	logic                   e_present;
	logic [CB-1:0]          e_xmin;
	logic [CB-1:0]          e_xmax;
	logic [CB-1:0]          e_ymin;
	logic [CB-1:0]          e_ymax;
	logic [ENTRY_W-1:0]     pix_entry;
	logic                   seen;
	logic [SUM_W-1:0]       x_lo_sum;
	logic [SUM_W-1:0]       x_hi_sum;
	logic [SUM_W-1:0]       y_lo_sum;
	logic [SUM_W-1:0]       y_hi_sum;
	logic [DIM_W-1:0]       box_w;
	logic [DIM_W-1:0]       box_h;
	bbt_pkg::rpt_t          rpt;

	bbt_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.settings (settings)
	);

	// Input acceptance
	assign s1_adv      = (s1_func_q == bbt_pkg::FUNC_PIXEL) || s2_ready;
	assign items.ready = !clr_busy_q && (!s1_valid_q || s1_adv);
	assign in_xfer     = items.valid && items.ready;
	assign idx_in      = items.label_value[AW-1:0];
	assign in_range_in = {1'b0, items.label_value} < (bbt_pkg::LABEL_W + 1)'(LABEL_ENTRIES);

	// Clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			if (clr_idx_q == AW'(LABEL_ENTRIES - 1)) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_idx_q <= clr_idx_q + AW'(1);
			end
		end
	end

	// Memory write port: clearing pass or write-back of the table stage
	always_comb begin
		if (clr_busy_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_idx_q;
			mem_wdata = '0;
		end else begin
			mem_we    = s1_valid_q && s1_adv && s1_inrange_q;
			mem_waddr = s1_idx_q;
			mem_wdata = (s1_func_q == bbt_pkg::FUNC_PIXEL) ? pix_entry : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			box_mem[mem_waddr] <= mem_wdata;
		end
	end

	// Memory read port, registered
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			rdata_s1 <= box_mem[idx_in];
		end
	end

	// Table stage registers; forward a write landing on the same entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (items.ready) begin
			s1_valid_q <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			s1_func_q     <= bbt_pkg::func_t'(items.func);
			s1_x_q        <= CB'(items.pixel_x);
			s1_y_q        <= CB'(items.pixel_y);
			s1_label_q    <= items.label_value;
			s1_inrange_q  <= in_range_in;
			s1_idx_q      <= idx_in;
			s1_fwd_q      <= mem_we && (mem_waddr == idx_in);
			s1_fwd_data_q <= mem_wdata;
		end
	end

	assign entry_s1 = s1_fwd_q ? s1_fwd_data_q : rdata_s1;
	assign {e_present, e_xmin, e_xmax, e_ymin, e_ymax} = entry_s1;

	// Pixel update: start a box or widen it
	always_comb begin
		if (!e_present) begin
			pix_entry = {1'b1, s1_x_q, s1_x_q, s1_y_q, s1_y_q};
		end else begin
			pix_entry = {1'b1,
				(s1_x_q < e_xmin) ? s1_x_q : e_xmin,
				(s1_x_q > e_xmax) ? s1_x_q : e_xmax,
				(s1_y_q < e_ymin) ? s1_y_q : e_ymin,
				(s1_y_q > e_ymax) ? s1_y_q : e_ymax};
		end
	end

	// Dropped-label flag: set by a pixel beyond the table, cleared by a report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dropped_q <= 1'b0;
		end else if (s1_valid_q && s1_adv) begin
			if (s1_func_q == bbt_pkg::FUNC_REPORT) begin
				dropped_q <= 1'b0;
			end else if (!s1_inrange_q) begin
				dropped_q <= 1'b1;
			end
		end
	end

	// Report fields: offset box with exclusive max edges, and box size
	assign seen     = s1_inrange_q && e_present;
	assign x_lo_sum = SUM_W'(e_xmin) + SUM_W'(settings.x_off);
	assign x_hi_sum = SUM_W'(e_xmax) + SUM_W'(settings.x_off) + SUM_W'(1);
	assign y_lo_sum = SUM_W'(e_ymin) + SUM_W'(settings.y_off);
	assign y_hi_sum = SUM_W'(e_ymax) + SUM_W'(settings.y_off) + SUM_W'(1);
	assign box_w    = DIM_W'(e_xmax) - DIM_W'(e_xmin) + DIM_W'(1);
	assign box_h    = DIM_W'(e_ymax) - DIM_W'(e_ymin) + DIM_W'(1);

	always_comb begin
		rpt.label        = s1_label_q;
		rpt.seen         = seen;
		rpt.out_of_range = !s1_inrange_q || dropped_q;
		rpt.xmin         = seen ? x_lo_sum[bbt_pkg::BOX_MIN_W-1:0] : '0;
		rpt.xmax         = seen ? x_hi_sum[bbt_pkg::BOX_MAX_W-1:0] : '0;
		rpt.ymin         = seen ? y_lo_sum[bbt_pkg::BOX_MIN_W-1:0] : '0;
		rpt.ymax         = seen ? y_hi_sum[bbt_pkg::BOX_MAX_W-1:0] : '0;
	end

	assign rpt_push = s1_valid_q && (s1_func_q == bbt_pkg::FUNC_REPORT);

	bbt_area_check #(
		.COORD_BITS (COORD_BITS)
	) u_area (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (rpt_push),
		.rpt      (rpt),
		.box_w    (box_w),
		.box_h    (box_h),
		.area     (settings.area),
		.s2_ready (s2_ready),
		.results  (results)
	);

	// Checks
	`BBT_ASSERT_IMP(a_clr_no_item, clk, arst_n, clr_busy_q, !s1_valid_q, "item in table stage during clearing")
	`BBT_ASSERT_NXT(a_clr_once, clk, arst_n, !clr_busy_q, !clr_busy_q, "clearing pass restarted")
	`BBT_ASSERT_NXT(a_fwd_src, clk, arst_n, in_xfer && clr_busy_q, 1'b0, "item taken while clearing")

endmodule

`default_nettype wire

// ----- rtl/core/bbt_cfg_regs.sv -----
// Region offset and size registers, plus the registered region area.
// Depends on bbt_pkg and bbt_intf (bbt_cfg_if).
`default_nettype none

module bbt_cfg_regs (
	input  wire logic      clk,
	input  wire logic      arst_n,
	bbt_cfg_if.sink        cfg,
	output bbt_pkg::cfg_t  settings
);

	logic [bbt_pkg::OFFS_W-1:0]   x_off_q;
	logic [bbt_pkg::OFFS_W-1:0]   y_off_q;
	logic [bbt_pkg::REGION_W-1:0] width_q;
	logic [bbt_pkg::REGION_W-1:0] height_q;
	logic [bbt_pkg::AREA_W-1:0]   area_q;
	logic                         wr_xfer;

	// Writes are always taken
	assign cfg.ready = 1'b1;
	assign wr_xfer   = cfg.valid && cfg.ready;

	// Register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_off_q  <= '0;
			y_off_q  <= '0;
			width_q  <= bbt_pkg::REGION_WIDTH_RST;
			height_q <= bbt_pkg::REGION_HEIGHT_RST;
		end else if (wr_xfer) begin
			unique case (bbt_pkg::cfg_reg_t'(cfg.index))
				bbt_pkg::REG_X_OFFSET: x_off_q  <= cfg.data[bbt_pkg::OFFS_W-1:0];
				bbt_pkg::REG_Y_OFFSET: y_off_q  <= cfg.data[bbt_pkg::OFFS_W-1:0];
				bbt_pkg::REG_WIDTH:    width_q  <= cfg.data[bbt_pkg::REGION_W-1:0];
				bbt_pkg::REG_HEIGHT:   height_q <= cfg.data[bbt_pkg::REGION_W-1:0];
				default: ;
			endcase
		end
	end

	// Region area, registered from the size registers
	always_ff @(posedge clk) begin
		area_q <= bbt_pkg::AREA_W'(width_q) * bbt_pkg::AREA_W'(height_q);
	end

	assign settings.x_off = x_off_q;
	assign settings.y_off = y_off_q;
	assign settings.area  = area_q;

endmodule

`default_nettype wire

// ----- rtl/core/bbt_area_check.sv -----
// Report stage: box area test against the region area, and the result register.
// Depends on bbt_pkg, bbt_intf (bbt_result_if) and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module bbt_area_check #(
	parameter int COORD_BITS = bbt_pkg::COORD_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	input  wire bbt_pkg::rpt_t               rpt,
	input  wire logic [COORD_BITS:0]         box_w,
	input  wire logic [COORD_BITS:0]         box_h,
	input  wire logic [bbt_pkg::AREA_W-1:0]  area,
	output logic                             s2_ready,
	bbt_result_if.source                     results
);

	localparam int DIM_W  = COORD_BITS + 1;
	localparam int PROD_W = 2 * DIM_W;
	localparam int CMP_W  = (PROD_W + 1 > bbt_pkg::AREA_W) ? PROD_W + 1 : bbt_pkg::AREA_W;

	logic                s2_valid_q;
	bbt_pkg::rpt_t       rpt_s2;
	logic [DIM_W-1:0]    w_s2;
	logic [DIM_W-1:0]    h_s2;
	logic [PROD_W-1:0]   box_area;
	logic [CMP_W-1:0]    twice_area;
	logic [CMP_W-1:0]    region_area;
	logic                kept;
	logic                s2_move;
	logic                out_valid_q;
	bbt_pkg::rpt_t       out_q;
	logic                kept_q;

	// Box area and the keep decision
	assign box_area    = PROD_W'(w_s2) * PROD_W'(h_s2);
	assign twice_area  = CMP_W'({box_area, 1'b0});
	assign region_area = CMP_W'(area);
	assign kept        = rpt_s2.seen && !(twice_area > region_area);

	// Stage handshake
	assign s2_move  = s2_valid_q && (!out_valid_q || results.ready);
	assign s2_ready = !s2_valid_q || s2_move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (s2_ready) begin
			s2_valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready && push) begin
			rpt_s2 <= rpt;
			w_s2   <= box_w;
			h_s2   <= box_h;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_move) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_move) begin
			out_q  <= rpt_s2;
			kept_q <= kept;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.report_label = out_q.label;
	assign results.seen         = out_q.seen;
	assign results.kept         = kept_q;
	assign results.out_of_range = out_q.out_of_range;
	assign results.box_xmin     = out_q.xmin;
	assign results.box_xmax     = out_q.xmax;
	assign results.box_ymin     = out_q.ymin;
	assign results.box_ymax     = out_q.ymax;

	// Checks
	`BBT_ASSERT_NXT(a_s2_hold, clk, arst_n, s2_valid_q && !s2_move, s2_valid_q, "report lost in area stage")
	`BBT_ASSERT_IMP(a_kept_seen, clk, arst_n, results.valid && results.kept, results.seen, "kept without seen")

endmodule

`default_nettype wire

// ----- verif/label_bounding_box_table_top_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for label_bounding_box_table_top: pixel and report transfers,
// local box table prediction, field-by-field result checks.
// Depends on bbt_pkg, bbt_intf and the block's RTL.

module label_bounding_box_table_top_tb;
	import bbt_pkg::*;

	localparam int ENTRIES       = LABEL_ENTRIES_DEF;
	localparam int CLK_HALF      = 2;
	localparam int RESET_CYCLES  = 11;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int MAX_PRINTS    = 100;
	localparam int PHASE_ITEMS   = 560;

	typedef struct packed {
		func_t              func;
		logic [PIX_W-1:0]   x;
		logic [PIX_W-1:0]   y;
		logic [LABEL_W-1:0] label;
	} label_item_t;

	typedef struct packed {
		logic [LABEL_W-1:0]   label;
		logic                 seen;
		logic                 kept;
		logic                 out_of_range;
		logic [BOX_MIN_W-1:0] xmin;
		logic [BOX_MAX_W-1:0] xmax;
		logic [BOX_MIN_W-1:0] ymin;
		logic [BOX_MAX_W-1:0] ymax;
	} box_report_t;

	logic clk = 1'b0;
	logic arst_n;

	bbt_item_if   items_if ();
	bbt_result_if results_if ();
	bbt_cfg_if    cfg_if ();

	label_bounding_box_table_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_if),
		.results (results_if),
		.cfg     (cfg_if)
	);

	// Local copy of the box table and region settings
	logic                box_present [ENTRIES];
	logic [PIX_W-1:0]    box_xmin [ENTRIES];
	logic [PIX_W-1:0]    box_xmax [ENTRIES];
	logic [PIX_W-1:0]    box_ymin [ENTRIES];
	logic [PIX_W-1:0]    box_ymax [ENTRIES];
	logic                drop_pending;
	logic [OFFS_W-1:0]   x_off;
	logic [OFFS_W-1:0]   y_off;
	logic [REGION_W-1:0] region_w;
	logic [REGION_W-1:0] region_h;

	box_report_t pending_reports[$];

	int error_count = 0;
	int items_sent = 0;
	int reports_checked = 0;
	int kept_count = 0;
	int oor_count = 0;
	int settings_used = 1;
	int send_idle_pct = 35;
	int recv_idle_pct = 62;

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// Run limit
	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	// Result side stalls at random
	always @(negedge clk) begin
		results_if.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic report_mismatch(input string msg);
		if (error_count < MAX_PRINTS)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic check_field(input string name, input logic [15:0] lbl,
			input logic [31:0] got, input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("label %0d %s: got %0h, expected %0h",
				lbl, name, got, want));
	endtask

	// Compare each result transfer with the oldest expected report
	always @(posedge clk) begin : check_reports
		box_report_t got;
		box_report_t want;
		if (arst_n && results_if.valid === 1'b1 && results_if.ready === 1'b1) begin
			got.label        = results_if.report_label;
			got.seen         = results_if.seen;
			got.kept         = results_if.kept;
			got.out_of_range = results_if.out_of_range;
			got.xmin         = results_if.box_xmin;
			got.xmax         = results_if.box_xmax;
			got.ymin         = results_if.box_ymin;
			got.ymax         = results_if.box_ymax;
			if (pending_reports.size() == 0) begin
				report_mismatch($sformatf("unexpected result for label %0d", got.label));
			end else begin
				want = pending_reports.pop_front();
				check_field("report_label", want.label, got.label, want.label);
				check_field("seen", want.label, got.seen, want.seen);
				check_field("kept", want.label, got.kept, want.kept);
				check_field("out_of_range", want.label, got.out_of_range, want.out_of_range);
				check_field("box_xmin", want.label, got.xmin, want.xmin);
				check_field("box_xmax", want.label, got.xmax, want.xmax);
				check_field("box_ymin", want.label, got.ymin, want.ymin);
				check_field("box_ymax", want.label, got.ymax, want.ymax);
				reports_checked++;
				if (want.kept)
					kept_count++;
				if (want.out_of_range)
					oor_count++;
			end
		end
	end

	task automatic clear_box(input int idx);
		box_present[idx] = 1'b0;
		box_xmin[idx] = '0;
		box_xmax[idx] = '0;
		box_ymin[idx] = '0;
		box_ymax[idx] = '0;
	endtask

	// Update the local table for one accepted item; a report queues its result
	task automatic track_boxes(input label_item_t it);
		box_report_t r;
		longint unsigned w;
		longint unsigned h;
		longint unsigned area;
		int idx;
		logic in_range;
		in_range = (it.label < ENTRIES);
		idx = in_range ? int'(it.label) : 0;
		if (it.func == FUNC_PIXEL) begin
			if (!in_range) begin
				drop_pending = 1'b1;
			end else if (!box_present[idx]) begin
				box_present[idx] = 1'b1;
				box_xmin[idx] = it.x;
				box_xmax[idx] = it.x;
				box_ymin[idx] = it.y;
				box_ymax[idx] = it.y;
			end else begin
				if (it.x < box_xmin[idx]) box_xmin[idx] = it.x;
				if (it.x > box_xmax[idx]) box_xmax[idx] = it.x;
				if (it.y < box_ymin[idx]) box_ymin[idx] = it.y;
				if (it.y > box_ymax[idx]) box_ymax[idx] = it.y;
			end
		end else begin
			r = '0;
			r.label = it.label;
			r.out_of_range = !in_range || drop_pending;
			drop_pending = 1'b0;
			if (in_range && box_present[idx]) begin
				w = 64'(box_xmax[idx]) - 64'(box_xmin[idx]) + 1;
				h = 64'(box_ymax[idx]) - 64'(box_ymin[idx]) + 1;
				area = 64'(region_w) * 64'(region_h);
				r.seen = 1'b1;
				r.kept = (2 * w * h <= area);
				r.xmin = BOX_MIN_W'(box_xmin[idx]) + BOX_MIN_W'(x_off);
				r.xmax = BOX_MAX_W'(box_xmax[idx]) + BOX_MAX_W'(x_off) + 1'b1;
				r.ymin = BOX_MIN_W'(box_ymin[idx]) + BOX_MIN_W'(y_off);
				r.ymax = BOX_MAX_W'(box_ymax[idx]) + BOX_MAX_W'(y_off) + 1'b1;
			end
			if (in_range)
				clear_box(idx);
			pending_reports = {pending_reports, r};
		end
	endtask

	// One item transfer, with random idle cycles ahead of it
	task automatic send_item(input label_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			items_if.valid <= 1'b0;
		end
		@(negedge clk);
		items_if.valid       <= 1'b1;
		items_if.func        <= it.func;
		items_if.pixel_x     <= it.x;
		items_if.pixel_y     <= it.y;
		items_if.label_value <= it.label;
		do @(posedge clk); while (items_if.ready !== 1'b1);
		track_boxes(it);
		items_sent++;
	endtask

	task automatic send_pixel(input logic [LABEL_W-1:0] lbl, input logic [PIX_W-1:0] x,
			input logic [PIX_W-1:0] y);
		label_item_t it;
		it.func = FUNC_PIXEL;
		it.x = x;
		it.y = y;
		it.label = lbl;
		send_item(it);
	endtask

	// Report items carry random filler coordinates, which the block ignores
	task automatic send_report(input logic [LABEL_W-1:0] lbl);
		label_item_t it;
		it.func = FUNC_REPORT;
		it.x = PIX_W'($urandom);
		it.y = PIX_W'($urandom);
		it.label = lbl;
		send_item(it);
	endtask

	// Release the item channel, wait for every report, then let pixels retire
	task automatic wait_idle();
		int guard;
		@(negedge clk);
		items_if.valid <= 1'b0;
		guard = 0;
		while (pending_reports.size() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		if (pending_reports.size() != 0) begin
			report_mismatch($sformatf("%0d reports never arrived", pending_reports.size()));
			pending_reports.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= value;
		do @(posedge clk); while (cfg_if.ready !== 1'b1);
		case (idx)
			REG_X_OFFSET: x_off = value[OFFS_W-1:0];
			REG_Y_OFFSET: y_off = value[OFFS_W-1:0];
			REG_WIDTH:    region_w = value;
			REG_HEIGHT:   region_h = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	function automatic logic [CFG_DATA_W-1:0] pick_offset();
		case ($urandom_range(3))
			0: return '0;
			1: return 13'h0FFF;
			default: return CFG_DATA_W'($urandom);
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_extent();
		case ($urandom_range(5))
			0: return 13'h1FFF;
			1: return 13'd4096;
			2: return 13'd1;
			default: return CFG_DATA_W'($urandom_range(4096, 64));
		endcase
	endfunction

	// Coordinate extremes, alternating bit patterns, a small kept box
	task automatic test_pixel_extremes();
		send_pixel(16'd0, 12'h000, 12'h000);
		send_pixel(16'd0, 12'hFFF, 12'hFFF);
		send_report(16'd0);
		send_pixel(16'd255, 12'hAAA, 12'h555);
		send_pixel(16'd255, 12'h555, 12'hAAA);
		send_report(16'd255);
		send_pixel(16'd1, 12'd5, 12'd7);
		send_report(16'd1);
	endtask

	// Unseen labels, labels beyond the table, and the sticky drop flag
	task automatic test_dropped_labels();
		send_report(16'd2);
		send_pixel(16'd256, 12'd3, 12'd4);
		send_report(16'd2);
		send_report(16'd2);
		send_report(16'hFFFF);
	endtask

	// Same label on consecutive transfers, report right after a pixel, reuse after clear
	task automatic test_same_label_runs();
		send_pixel(16'd7, 12'd100, 12'd200);
		send_pixel(16'd7, 12'd90, 12'd210);
		send_report(16'd7);
		send_report(16'd7);
		send_pixel(16'd7, 12'd1, 12'd1);
		send_report(16'd7);
	endtask

	// Largest offsets, zero area, and the area test at its boundary
	task automatic test_region_extremes();
		wait_idle();
		write_register(REG_X_OFFSET, 13'h0FFF);
		write_register(REG_Y_OFFSET, 13'h0FFF);
		write_register(REG_WIDTH, 13'd0);
		send_pixel(16'd3, 12'hFFF, 12'hFFF);
		send_report(16'd3);
		wait_idle();
		write_register(REG_WIDTH, 13'd1);
		write_register(REG_HEIGHT, 13'd1);
		send_pixel(16'd4, 12'd9, 12'd9);
		send_report(16'd4);
		wait_idle();
		write_register(REG_WIDTH, 13'd2);
		send_pixel(16'd4, 12'd9, 12'd9);
		send_report(16'd4);
		wait_idle();
		settings_used += 3;
	endtask

	// Blobs of pixels around a random center, mostly followed by their report,
	// mixed with stray pixels, stray reports and labels beyond the table
	task automatic test_random_blobs(input int budget);
		int target;
		int k;
		int npix;
		int span;
		logic [LABEL_W-1:0] lbl;
		logic [PIX_W-1:0] cx;
		logic [PIX_W-1:0] cy;
		wait_idle();
		write_register(REG_X_OFFSET, pick_offset());
		write_register(REG_Y_OFFSET, pick_offset());
		write_register(REG_WIDTH, pick_extent());
		write_register(REG_HEIGHT, pick_extent());
		settings_used++;
		target = items_sent + budget;
		while (items_sent < target) begin
			case ($urandom_range(9))
				0: lbl = LABEL_W'($urandom_range(65535, ENTRIES));
				1, 2: lbl = LABEL_W'($urandom_range(ENTRIES - 1));
				default: lbl = LABEL_W'($urandom_range(7));
			endcase
			case ($urandom_range(3))
				0: span = 1;
				1: span = 8;
				2: span = 64;
				default: span = 4096;
			endcase
			cx = PIX_W'($urandom);
			cy = PIX_W'($urandom);
			npix = $urandom_range(12, 1);
			for (k = 0; k < npix; k++) begin
				if ($urandom_range(19) == 0)
					send_pixel($urandom_range(1) ? LABEL_W'($urandom) : LABEL_W'($urandom_range(7)),
						PIX_W'($urandom), PIX_W'($urandom));
				send_pixel(lbl, cx + PIX_W'($urandom_range(span - 1)),
					cy + PIX_W'($urandom_range(span - 1)));
			end
			if ($urandom_range(9) != 0)
				send_report(lbl);
			if ($urandom_range(9) == 0)
				send_report($urandom_range(1) ? LABEL_W'($urandom) : LABEL_W'($urandom_range(15)));
		end
	endtask

	initial begin
		int i;
		items_if.valid       = 1'b0;
		items_if.func        = FUNC_PIXEL;
		items_if.pixel_x     = '0;
		items_if.pixel_y     = '0;
		items_if.label_value = '0;
		cfg_if.valid         = 1'b0;
		cfg_if.index         = REG_X_OFFSET;
		cfg_if.data          = '0;
		results_if.ready     = 1'b0;
		arst_n               = 1'b0;

		// Table cleared, registers at their reset values
		for (i = 0; i < ENTRIES; i++)
			clear_box(i);
		drop_pending = 1'b0;
		x_off = '0;
		y_off = '0;
		region_w = REGION_WIDTH_RST;
		region_h = REGION_HEIGHT_RST;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 35;
		recv_idle_pct = 62;
		test_pixel_extremes();
		test_dropped_labels();
		test_same_label_runs();
		test_region_extremes();

		test_random_blobs(PHASE_ITEMS);
		send_idle_pct = 62;
		recv_idle_pct = 35;
		test_random_blobs(PHASE_ITEMS);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_blobs(PHASE_ITEMS);
		wait_idle();

		$display("Run covered %0d item transfers and %0d checked reports over %0d region settings",
			items_sent, reports_checked, settings_used);
		$display("Reports kept: %0d, flagged out of range: %0d, mismatches: %0d",
			kept_count, oor_count, error_count);
		if (error_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
